FILE: hw/rtl/ptfa_pkg.sv
// Shared constants for the page table frame allocator.
// No dependencies.
`default_nettype none
package ptfa_pkg;
    localparam int ADDR_W  = 48;
    localparam int BYTES_W = 21;
    localparam int TASK_W  = 4;
    localparam int CNT_W   = 9;
    localparam int TOT_W   = 32;
    localparam int FREE_W  = 11;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;
endpackage
`default_nettype wire

FILE: hw/rtl/ptfa_frame_search.sv
// First-free frame allocator: frames are handed out lowest first and never freed.
// Depends on ptfa_pkg.
`default_nettype none
module ptfa_frame_search
    import ptfa_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    output logic                           done,
    output logic                           found,
    output logic [$clog2(FRAMES)-1:0]      frame
);
    localparam int FW = $clog2(FRAMES);
    // frames below next_reg are all taken, so next_reg is the lowest free frame
    logic [FW:0] next_reg;
    logic        run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_reg <= '0;
            run_reg  <= 1'b0;
        end
        else
        begin
            run_reg <= go;
            if (run_reg && found)
                next_reg <= next_reg + 1'b1;
        end
    end

    assign done  = run_reg;
    assign found = next_reg < (FW+1)'(FRAMES);
    assign frame = next_reg[FW-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/page_table_frame_allocator.sv
// Top level: request sequencer, page table memory, per-task totals.
// Depends on ptfa_pkg and ptfa_frame_search.
//
// Usage: pulse start with task_select, logical_address and request_bytes
// while busy is low. busy stays high while the request's pages are walked;
// done pulses for one cycle with the result fields valid. The receiver
// cannot stall; results must be captured in the done cycle.
// Per page: an out-of-range page takes the page step alone, a hit or a failure
// takes a table read and a check, a miss a read, a check and a frame take.
// After the last page come the end check and the totals step, then done;
// busy drops in the cycle after done. An invalid task has done high in the cycle
// right after acceptance. One request is in flight at a time.
// After reset a clearing pass walks the page table memory, one entry per
// cycle, with busy high.
// Reset leaves all frames free and all totals zero.
`default_nettype none
module page_table_frame_allocator
    import ptfa_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS  = 12,
    parameter int VIRTUAL_PAGES     = 1024,
    parameter int PHYSICAL_FRAMES   = 1024,
    parameter int TASK_COUNT        = 10,
    parameter int MAX_REQUEST_PAGES = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [TASK_W-1:0]  task_select,
    input  wire logic [ADDR_W-1:0]  logical_address,
    input  wire logic [BYTES_W-1:0] request_bytes,
    output logic                    done,
    output logic [CNT_W-1:0]        pages_hit,
    output logic [CNT_W-1:0]        pages_mapped,
    output logic [CNT_W-1:0]        pages_failed,
    output logic [CNT_W-1:0]        pages_out_of_range,
    output logic [TOT_W-1:0]        task_requested_total,
    output logic [TOT_W-1:0]        task_hit_total,
    output logic [FREE_W-1:0]       free_frames
);
    localparam int VPW   = $clog2(VIRTUAL_PAGES);
    localparam int FW    = $clog2(PHYSICAL_FRAMES);
    localparam int TW    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int DEPTH = TASK_COUNT * VIRTUAL_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PGW   = ADDR_W - PAGE_OFFSET_BITS;
    localparam int RCW   = $clog2(MAX_REQUEST_PAGES + 1);
    localparam int NPW   = BYTES_W - PAGE_OFFSET_BITS + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_PAGE  = 8'b00000100,
        S_CHECK = 8'b00001000,
        S_FIND  = 8'b00010000,
        S_TOTAL = 8'b00100000,
        S_DONE  = 8'b01000000
    } state_t;

    state_t state_reg, state_next;

    // page table memory: entry = valid bit and frame number (frame number kept, never read out)
    logic [FW:0] ptab [DEPTH];
    logic [FW:0] rd_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [FW:0]   wr_data;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0]     clr_reg;
    logic [TW-1:0]     task_reg;
    logic [PGW:0]      page_reg;
    logic [RCW-1:0]    left_reg;
    logic [RCW-1:0]    count_reg;
    logic [CNT_W-1:0]  hit_reg, map_reg, fail_reg, oor_reg;
    logic [FREE_W-1:0] free_reg;
    logic [TOT_W-1:0]  req_tot [TASK_COUNT];
    logic [TOT_W-1:0]  hit_tot [TASK_COUNT];
    logic [TOT_W-1:0]  out_req_reg, out_hit_reg;
    logic [AW-1:0]     base_reg;

    logic         fs_go, fs_done, fs_found;
    logic [FW-1:0] fs_frame;

    ptfa_frame_search #(.FRAMES(PHYSICAL_FRAMES)) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (fs_go),
        .done  (fs_done),
        .found (fs_found),
        .frame (fs_frame)
    );

    logic [NPW-1:0]   npages;
    logic [RCW-1:0]   req_count;
    logic             task_ok;
    logic             page_oor;
    logic [AW-1:0]    entry_addr;

    assign npages = NPW'(({1'b0, request_bytes} + {1'b0, BYTES_W'((1 << PAGE_OFFSET_BITS) - 1)})
                    >> PAGE_OFFSET_BITS);
    assign req_count = (npages > NPW'(MAX_REQUEST_PAGES)) ? RCW'(MAX_REQUEST_PAGES)
                                                          : RCW'(npages);
    assign task_ok  = {28'd0, task_select} < TASK_COUNT;
    assign page_oor = page_reg >= (PGW+1)'(VIRTUAL_PAGES);
    assign entry_addr = base_reg + AW'(page_reg[VPW-1:0]);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = entry_addr;
        wr_data = {1'b1, fs_frame};
        rd_addr = entry_addr;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_FIND && fs_done && fs_found)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ptab[wr_addr] <= wr_data;
        rd_reg <= ptab[rd_addr];
    end

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        fs_go = 1'b0;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(DEPTH-1)) state_next = S_IDLE;
            S_IDLE:  if (start) state_next = task_ok ? S_PAGE : S_DONE;
            S_PAGE:
            begin
                if (left_reg == '0)
                    state_next = S_TOTAL;
                else if (!page_oor)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_reg[FW])
                    state_next = S_PAGE;
                else if (free_reg == '0)
                    state_next = S_PAGE;
                else
                begin
                    fs_go = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_FIND:  if (fs_done) state_next = S_PAGE;
            S_TOTAL: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            free_reg  <= FREE_W'(PHYSICAL_FRAMES);
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                req_tot[i] <= '0;
                hit_tot[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_FIND && fs_done && fs_found)
                free_reg <= free_reg - 1'b1;
            if (state_reg == S_TOTAL)
            begin
                req_tot[task_reg] <= sat_add(req_tot[task_reg], TOT_W'(count_reg));
                hit_tot[task_reg] <= sat_add(hit_tot[task_reg], TOT_W'(hit_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                task_reg  <= TW'(task_select);
                base_reg  <= AW'(TW'(task_select) * VIRTUAL_PAGES);
                page_reg  <= {1'b0, logical_address[ADDR_W-1:PAGE_OFFSET_BITS]};
                left_reg  <= req_count;
                count_reg <= req_count;
                hit_reg   <= '0;
                map_reg   <= '0;
                fail_reg  <= '0;
                oor_reg   <= '0;
                out_req_reg <= '0;
                out_hit_reg <= '0;
            end
            S_PAGE:
            begin
                if (left_reg != '0 && page_oor)
                begin
                    oor_reg  <= oor_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    page_reg <= page_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (rd_reg[FW] || free_reg == '0)
                begin
                    if (rd_reg[FW])
                        hit_reg <= hit_reg + 1'b1;
                    else
                        fail_reg <= fail_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    page_reg <= page_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                if (fs_done)
                begin
                    if (fs_found)
                        map_reg <= map_reg + 1'b1;
                    else
                        fail_reg <= fail_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    page_reg <= page_reg + 1'b1;
                end
            end
            S_TOTAL:
            begin
                out_req_reg <= sat_add(req_tot[task_reg], TOT_W'(count_reg));
                out_hit_reg <= sat_add(hit_tot[task_reg], TOT_W'(hit_reg));
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign pages_hit            = hit_reg;
    assign pages_mapped         = map_reg;
    assign pages_failed         = fail_reg;
    assign pages_out_of_range   = oor_reg;
    assign task_requested_total = out_req_reg;
    assign task_hit_total       = out_hit_reg;
    assign free_frames          = free_reg;
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for page_table_frame_allocator: random and directed requests,
// checked against an in-bench model of the page tables and frame allocator.
// Depends on ptfa_pkg and the RTL top level.
module tb;
    import ptfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFS     = 12;
    localparam int VPAGES   = 1024;
    localparam int FRAMES   = 1024;
    localparam int TASKS    = 10;
    localparam int MAXPAGES = 256;
    localparam int LIMIT    = 10000000;

    typedef struct packed {
        logic [TASK_W-1:0]  tsk;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic               hold;  // wait for all results before this request
    } request_t;

    typedef struct packed {
        logic [CNT_W-1:0]  hit;
        logic [CNT_W-1:0]  mapped;
        logic [CNT_W-1:0]  failed;
        logic [CNT_W-1:0]  oor;
        logic [TOT_W-1:0]  req_tot;
        logic [TOT_W-1:0]  hit_tot;
        logic [FREE_W-1:0] free;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [TASK_W-1:0]  task_select = '0;
    logic [ADDR_W-1:0]  logical_address = '0;
    logic [BYTES_W-1:0] request_bytes = '0;
    logic busy, done;
    logic [CNT_W-1:0] pages_hit, pages_mapped, pages_failed, pages_out_of_range;
    logic [TOT_W-1:0] task_requested_total, task_hit_total;
    logic [FREE_W-1:0] free_frames;

    request_t      pending_reqs[$];
    alloc_result_t expected_results[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 24;
    bit  stim_done = 1'b0;
    bit  accepted = 1'b0;  // request on the ports was taken at the last rising edge

    // model state
    bit          page_valid[TASKS][VPAGES];
    bit          frame_used[FRAMES];
    int unsigned free_left = FRAMES;
    logic [TOT_W-1:0] req_totals[TASKS];
    logic [TOT_W-1:0] hit_totals[TASKS];

    page_table_frame_allocator u_top (.*);

    always #5 clk = ~clk;

    function automatic logic [TOT_W-1:0] sat_sum(logic [TOT_W-1:0] a, int unsigned b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + b;
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    function automatic alloc_result_t allocate_pages(request_t r);
        alloc_result_t res;
        longint unsigned first_page, cnt, pg;
        int f;
        bit got;
        res = '0;
        if (r.tsk < TASKS) begin
            first_page = r.addr >> OFFS;
            cnt = (longint'(r.bytes) + (1 << OFFS) - 1) >> OFFS;
            if (cnt > MAXPAGES) cnt = MAXPAGES;
            for (longint unsigned i = 0; i < cnt; i++) begin
                pg = first_page + i;
                if (pg >= VPAGES) res.oor++;
                else if (page_valid[r.tsk][pg]) res.hit++;
                else begin
                    got = 1'b0;
                    for (f = 0; f < FRAMES && !got; f++) begin
                        if (!frame_used[f]) begin
                            frame_used[f] = 1'b1;
                            free_left--;
                            got = 1'b1;
                        end
                    end
                    if (got) begin
                        page_valid[r.tsk][pg] = 1'b1;
                        res.mapped++;
                    end else res.failed++;
                end
            end
            req_totals[r.tsk] = sat_sum(req_totals[r.tsk], int'(cnt));
            hit_totals[r.tsk] = sat_sum(hit_totals[r.tsk], res.hit);
            res.req_tot = req_totals[r.tsk];
            res.hit_tot = hit_totals[r.tsk];
        end
        res.free = free_left[FREE_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic request_t make_req(int t, logic [ADDR_W-1:0] a, int b);
        request_t r;
        r.tsk = TASK_W'(t);
        r.addr = a;
        r.bytes = BYTES_W'(b);
        r.hold = 1'b0;
        return r;
    endfunction

    // mostly small requests in range, some large, some wild addresses
    function automatic request_t rand_req();
        request_t r;
        int sel;
        sel = $urandom_range(99);
        r.tsk = (sel < 5) ? TASK_W'($urandom_range(15)) : TASK_W'($urandom_range(TASKS - 1));
        if (sel < 10) r.addr = ADDR_W'({$urandom, $urandom});
        else r.addr = ADDR_W'({$urandom, $urandom} % ((VPAGES + 8) << OFFS));
        case ($urandom_range(9))
            0: r.bytes = BYTES_W'({$urandom} % (1 << BYTES_W));
            1: r.bytes = BYTES_W'($urandom_range(1 << 20));
            2: r.bytes = '0;
            default: r.bytes = BYTES_W'($urandom_range(16 << OFFS));
        endcase
        r.hold = ($urandom_range(199) == 0);
        return r;
    endfunction

    initial begin
        request_t r;
        for (int t = 0; t < TASKS; t++) begin
            req_totals[t] = '0;
            hit_totals[t] = '0;
        end
        pending_reqs.push_back(make_req(0, 0, 1));
        pending_reqs.push_back(make_req(0, 0, 4096));         // hit
        pending_reqs.push_back(make_req(TASKS - 1, '1, 1 << 20)); // all out of range
        pending_reqs.push_back(make_req(10, 48'h1234, 100));  // invalid task
        pending_reqs.push_back(make_req(15, '1, '1));
        pending_reqs.push_back(make_req(1, 0, 0));            // zero bytes
        pending_reqs.push_back(make_req(2, 48'h5555_5555_5555, 21'h1F_FFFF)); // clamp
        pending_reqs.push_back(make_req(3, ADDR_W'((VPAGES - 2) << OFFS), 5 << OFFS)); // straddle
        pending_reqs.push_back(make_req(4, 48'hAAAA_AAAA_AAAA, 21'h0A_AAAA));
        pending_reqs.push_back(make_req(5, 48'h0000_0000_0FFF, 2));
        // exhaust the frame pool, then fail
        for (int t = 0; t < 6; t++) pending_reqs.push_back(make_req(t, 0, 1 << 20));
        r = make_req(7, 0, 1 << 20);
        r.hold = 1'b1;
        pending_reqs.push_back(r);
        for (int i = 0; i < 1900; i++) pending_reqs.push_back(rand_req());
        wait (pending_reqs.size() < 1300);
        send_idle_pct = 86;
        wait (pending_reqs.size() < 650);
        send_idle_pct = 0;
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (start && !accepted) begin
                // still waiting for acceptance
            end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct
                         && !(pending_reqs[0].hold && expected_results.size() > 0)) begin
                request_t r;
                r = pending_reqs.pop_front();
                accepted = 1'b0;
                task_select <= r.tsk;
                logical_address <= r.addr;
                request_bytes <= r.bytes;
                start <= 1'b1;
            end else begin
                accepted = 1'b0;
                start <= 1'b0;
                if (pending_reqs.size() == 0) stim_done = 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        alloc_result_t want;
        if (rst_n) begin
            cycles++;
            if (start && !busy) begin
                expected_results.push_back(allocate_pages(
                    make_req(task_select, logical_address, request_bytes)));
                accepted = 1'b1;
            end
            if (done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("done without request", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (pages_hit !== want.hit) report_mismatch("pages_hit", pages_hit, want.hit);
                    if (pages_mapped !== want.mapped)
                        report_mismatch("pages_mapped", pages_mapped, want.mapped);
                    if (pages_failed !== want.failed)
                        report_mismatch("pages_failed", pages_failed, want.failed);
                    if (pages_out_of_range !== want.oor)
                        report_mismatch("pages_out_of_range", pages_out_of_range, want.oor);
                    if (task_requested_total !== want.req_tot)
                        report_mismatch("task_requested_total", task_requested_total,
                                        want.req_tot);
                    if (task_hit_total !== want.hit_tot)
                        report_mismatch("task_hit_total", task_hit_total, want.hit_tot);
                    if (free_frames !== want.free)
                        report_mismatch("free_frames", free_frames, want.free);
                end
            end
            if (cycles > LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done && !start && expected_results.size() == 0);
        repeat (1000) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end
endmodule

FILE: page_table_frame_allocator.f
hw/rtl/ptfa_pkg.sv
hw/rtl/ptfa_frame_search.sv
hw/rtl/page_table_frame_allocator.sv
dv/tb.sv
